// ----- sv/mtqs_pkg.sv -----
// Shared types and constants for the triangle quality statistics block.
package mtqs_pkg;

  localparam int COORD_BITS = 16;
  localparam int Q_BITS = 17;
  localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic                         last_face;
  } in_t;

  typedef struct packed {
    logic [Q_BITS-1:0] face_quality;
    logic [Q_BITS-1:0] min_quality;
    logic [Q_BITS-1:0] mean_quality;
    logic              degenerate;
    logic              is_last;
  } out_t;

  typedef enum logic {
    RDU_SQRT,
    RDU_DIV
  } rdu_mode_t;

  typedef struct packed {
    logic      start;
    rdu_mode_t mode;
  } rdu_ctl_t;

endpackage

// ----- sv/mtqs_rdu.sv -----
// Bit-serial square root and restoring divider sharing one subtractor.
module mtqs_rdu import mtqs_pkg::*; #(
  parameter int RW  = 106,
  parameter int AW  = 55,
  parameter int DVW = 53
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rdu_ctl_t            ctl,
  input  logic [RW-1:0]       rad,
  input  logic [DVW-1:0]      dividend,
  input  logic [AW-1:0]       divisor,
  output logic                done,
  output logic [RW/2-1:0]     res
);

  localparam int QW = RW / 2;
  localparam int CW = $clog2(QW + 1);

  logic            busy_r, done_r;
  rdu_mode_t       mode_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   rem_r, dvs_r;
  logic [QW-1:0]   root_r;
  logic [RW-1:0]   rad_r;
  logic [Q_BITS-1:0] lo_r;

  logic [AW-1:0]   rem_sh, trial;
  logic [AW:0]     diff;
  logic            ge;

  always_comb begin
    if (mode_r == RDU_SQRT) begin
      rem_sh = {rem_r[AW-3:0], rad_r[RW-1:RW-2]};
      trial  = AW'({root_r, 2'b01});
    end else begin
      rem_sh = {rem_r[AW-2:0], lo_r[Q_BITS-1]};
      trial  = dvs_r;
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = !diff[AW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= RDU_SQRT;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start && !busy_r) begin
        busy_r <= 1'b1;
        mode_r <= ctl.mode;
        root_r <= '0;
        rad_r  <= rad;
        dvs_r  <= divisor;
        lo_r   <= dividend[Q_BITS-1:0];
        if (ctl.mode == RDU_SQRT) begin
          rem_r <= '0;
          cnt_r <= CW'(QW);
        end else begin
          rem_r <= AW'(dividend >> Q_BITS);
          cnt_r <= CW'(Q_BITS);
        end
      end else if (busy_r) begin
        rem_r  <= ge ? diff[AW-1:0] : rem_sh;
        root_r <= {root_r[QW-2:0], ge};
        rad_r  <= rad_r << 2;
        lo_r   <= lo_r << 1;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = root_r;

endmodule

// ----- sv/mesh_triangle_quality_stats_core.sv -----
// Top level: triangle shape quality with running mesh statistics.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one triangle request:
//    nine signed vertex coordinates and a last_face flag.
//  - Output channel out_valid/out_ready/out_data returns one result per
//    request: face quality (Q1.16), running minimum, mean (last face only),
//    degenerate and is_last flags.
//  - Sequence: a multiply phase on one shared multiplier (24 products),
//    a prep step, a square root of the scaled area term (RW/2 = 53
//    steps), a 17-step divide by the edge sum, then stats and output
//    load. A new request is taken only after the result is loaded. A last
//    face adds the mean divide. Degenerate faces skip root and divide.
//  - One request at a time: in_ready is high only while the sequencer idles.
//  - The result sits in an output register; a stalled receiver holds the
//    block in its final state until out_ready frees the register.
//  - Reset clears face count and quality sum and sets the minimum to one.
//  - The last face reports the mean, then clears the statistics.
module mesh_triangle_quality_stats_core import mtqs_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;            // edge vector component
  localparam int H    = C + 1;            // half of cross magnitude
  localparam int MW   = C + 2;            // multiplier operand (signed)
  localparam int PW   = 2 * MW;
  localparam int XW   = 2 * C + 3;        // cross component, signed
  localparam int MG   = 2 * H;            // cross magnitude
  localparam int T2W  = 4 * H + 2;
  localparam int RW   = T2W + 36;         // 12 * T2 * 2^32
  localparam int QW   = RW / 2;
  localparam int SW   = 2 * C + 6;
  localparam int AW   = QW + 2;
  localparam int SUMW = COUNT_BITS + Q_BITS;
  localparam int DVW  = (QW > SUMW) ? QW : SUMW;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [4:0] LAST_STEP = 5'd23;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_SQW, S_DQ, S_DQW, S_STAT, S_DM, S_DMW, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_CRP, ACC_CRN, ACC_S, ACC_HH, ACC_HL, ACC_LL
  } acc_t;

  state_t st_r;
  logic [4:0] k_r;
  logic signed [DW-1:0] d_r [9];   // ux uy uz vx vy vz wx wy wz
  logic signed [XW-1:0] cr_r [3];
  logic [SW-1:0]  s_r;
  logic [T2W-1:0] t2_r;
  logic signed [PW-1:0] prod_r;
  acc_t acc_r;
  logic [1:0] ci_r;
  logic [Q_BITS-1:0] q_r, mean_r, min_r;
  logic deg_r, last_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [SUMW-1:0] sum_r;
  logic out_valid_r;
  out_t out_r;
  logic out_load;

  // operand selection for the shared multiplier
  logic signed [MW-1:0] opa, opb;
  acc_t acc_k;
  logic [1:0] ci_k, mi;
  logic signed [XW-1:0] crsel;
  logic [MG-1:0] mag;
  logic signed [MW-1:0] hi_op, lo_op;

  always_comb begin
    mi = 2'd0;
    if (k_r >= 5'd18) mi = 2'd1;
    if (k_r >= 5'd21) mi = 2'd2;
    crsel = cr_r[mi];
    mag   = crsel[XW-1] ? MG'(-crsel) : MG'(crsel);
    hi_op = MW'({1'b0, mag[MG-1:H]});
    lo_op = MW'({1'b0, mag[H-1:0]});
    opa = '0; opb = '0; acc_k = ACC_NONE; ci_k = 2'd0;
    case (k_r)
      5'd0: begin opa = MW'(d_r[1]); opb = MW'(d_r[5]); acc_k = ACC_CRP; ci_k = 2'd0; end
      5'd1: begin opa = MW'(d_r[2]); opb = MW'(d_r[4]); acc_k = ACC_CRN; ci_k = 2'd0; end
      5'd2: begin opa = MW'(d_r[2]); opb = MW'(d_r[3]); acc_k = ACC_CRP; ci_k = 2'd1; end
      5'd3: begin opa = MW'(d_r[0]); opb = MW'(d_r[5]); acc_k = ACC_CRN; ci_k = 2'd1; end
      5'd4: begin opa = MW'(d_r[0]); opb = MW'(d_r[4]); acc_k = ACC_CRP; ci_k = 2'd2; end
      5'd5: begin opa = MW'(d_r[1]); opb = MW'(d_r[3]); acc_k = ACC_CRN; ci_k = 2'd2; end
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14: begin
        opa = MW'(d_r[4'(k_r - 5'd6)]);
        opb = opa;
        acc_k = ACC_S;
      end
      5'd15, 5'd18, 5'd21: begin opa = hi_op; opb = hi_op; acc_k = ACC_HH; end
      5'd16, 5'd19, 5'd22: begin opa = hi_op; opb = lo_op; acc_k = ACC_HL; end
      5'd17, 5'd20, 5'd23: begin opa = lo_op; opb = lo_op; acc_k = ACC_LL; end
      default: begin acc_k = ACC_NONE; end
    endcase
  end

  // shared root / divide unit
  rdu_ctl_t rdu_ctl;
  logic [RW-1:0]  rad_w;
  logic [DVW-1:0] rdu_dvd;
  logic [AW-1:0]  rdu_dvs;
  logic           rdu_done;
  logic [QW-1:0]  rdu_res;
  logic [Q_BITS-1:0] rdu_q;

  always_comb begin
    rdu_ctl.start = (st_r == S_PREP && t2_r != '0) || st_r == S_DQ || st_r == S_DM;
    rdu_ctl.mode  = (st_r == S_PREP) ? RDU_SQRT : RDU_DIV;
    rdu_dvd = (st_r == S_DQ) ? DVW'(rdu_res) : DVW'(sum_r);
    rdu_dvs = (st_r == S_DQ) ? AW'(s_r) : AW'(count_r);
    rdu_q   = (rdu_res > QW'(Q_ONE)) ? Q_ONE : rdu_res[Q_BITS-1:0];
  end

  mtqs_rdu #(.RW(RW), .AW(AW), .DVW(DVW)) u_rdu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rdu_ctl),
    .rad      (rad_w),
    .dividend (rdu_dvd),
    .divisor  (rdu_dvs),
    .done     (rdu_done),
    .res      (rdu_res)
  );

  // radicand is loaded by the root unit at the prep edge
  logic [T2W+3:0] t2x12;
  assign t2x12 = ({t2_r, 3'b0} + {1'b0, t2_r, 2'b0});
  assign rad_w = {t2x12[RW-33:0], 32'b0};

  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      k_r         <= '0;
      acc_r       <= ACC_NONE;
      count_r     <= '0;
      sum_r       <= '0;
      min_r       <= Q_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            d_r[0] <= DW'(in_data.bx) - DW'(in_data.ax);
            d_r[1] <= DW'(in_data.by_coord) - DW'(in_data.ay);
            d_r[2] <= DW'(in_data.bz) - DW'(in_data.az);
            d_r[3] <= DW'(in_data.cx) - DW'(in_data.ax);
            d_r[4] <= DW'(in_data.cy) - DW'(in_data.ay);
            d_r[5] <= DW'(in_data.cz) - DW'(in_data.az);
            d_r[6] <= DW'(in_data.cx) - DW'(in_data.bx);
            d_r[7] <= DW'(in_data.cy) - DW'(in_data.by_coord);
            d_r[8] <= DW'(in_data.cz) - DW'(in_data.bz);
            last_r <= in_data.last_face;
            for (int i = 0; i < 3; i++) cr_r[i] <= '0;
            s_r   <= '0;
            t2_r  <= '0;
            k_r   <= '0;
            acc_r <= ACC_NONE;
            st_r  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= PW'(opa * opb);
          acc_r  <= acc_k;
          ci_r   <= ci_k;
          k_r    <= k_r + 1'b1;
          case (acc_r)
            ACC_CRP: cr_r[ci_r] <= cr_r[ci_r] + XW'(prod_r);
            ACC_CRN: cr_r[ci_r] <= cr_r[ci_r] - XW'(prod_r);
            ACC_S:   s_r <= s_r + SW'(prod_r);
            ACC_HH:  t2_r <= t2_r + (T2W'(unsigned'(prod_r)) << (2 * H));
            ACC_HL:  t2_r <= t2_r + (T2W'(unsigned'(prod_r)) << (H + 1));
            ACC_LL:  t2_r <= t2_r + T2W'(unsigned'(prod_r));
            default: ;
          endcase
          if (k_r == LAST_STEP + 5'd1) st_r <= S_PREP;
        end
        S_PREP: begin
          deg_r <= (t2_r == '0);
          if (t2_r == '0) begin
            q_r  <= '0;
            st_r <= S_STAT;
          end else begin
            st_r <= S_SQW;
          end
        end
        S_SQW: if (rdu_done) st_r <= S_DQ;
        S_DQ:  st_r <= S_DQW;
        S_DQW: begin
          if (rdu_done) begin
            q_r  <= rdu_q;
            st_r <= S_STAT;
          end
        end
        S_STAT: begin
          if (q_r < min_r) min_r <= q_r;
          if (count_r != CNT_MAX) begin
            count_r <= count_r + 1'b1;
            sum_r   <= sum_r + SUMW'(q_r);
          end
          mean_r <= '0;
          st_r   <= last_r ? S_DM : S_OUT;
        end
        S_DM:  st_r <= S_DMW;
        S_DMW: begin
          if (rdu_done) begin
            mean_r <= rdu_q;
            st_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_r.face_quality <= q_r;
            out_r.min_quality  <= min_r;
            out_r.mean_quality <= mean_r;
            out_r.degenerate   <= deg_r;
            out_r.is_last      <= last_r;
            if (last_r) begin
              count_r <= '0;
              sum_r   <= '0;
              min_r   <= Q_ONE;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // degenerate faces report zero quality
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.face_quality == '0)
    else $error("degenerate face with nonzero quality");

  // the running minimum includes the current face
  a_min_le_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.min_quality <= out_data.face_quality)
    else $error("minimum above face quality");

  // mean only on the closing face, never above one
  a_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_last || out_data.mean_quality == '0) &&
                  out_data.mean_quality <= Q_ONE)
    else $error("bad mean field");

endmodule

// ----- bench/mtqs_quality_checker.sv -----
// Scoreboard for the triangle quality block: predicts each result and compares it.
module mtqs_quality_checker import mtqs_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   degen_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  logic [63:0]       face_total;
  logic [63:0]       quality_total;
  logic [Q_BITS-1:0] worst_quality;
  out_t              expected_results[$];

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Largest q in [0, 1.0] with (q*S)^2 <= 12 * 2^32 * T2; area term is exact.
  function automatic logic [Q_BITS-1:0] shape_quality(in_t t, output logic degen);
    longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic [127:0] t2, rhs, s, lhs, c;
    logic [Q_BITS-1:0] q, cand;
    ux = longint'(t.bx) - longint'(t.ax);
    uy = longint'(t.by_coord) - longint'(t.ay);
    uz = longint'(t.bz) - longint'(t.az);
    vx = longint'(t.cx) - longint'(t.ax);
    vy = longint'(t.cy) - longint'(t.ay);
    vz = longint'(t.cz) - longint'(t.az);
    wx = vx - ux;
    wy = vy - uy;
    wz = vz - uz;
    c = 128'(abs64(uy * vz - uz * vy));
    t2 = c * c;
    c = 128'(abs64(uz * vx - ux * vz));
    t2 = t2 + c * c;
    c = 128'(abs64(ux * vy - uy * vx));
    t2 = t2 + c * c;
    s = 128'(ux * ux + uy * uy + uz * uz + vx * vx + vy * vy + vz * vz
             + wx * wx + wy * wy + wz * wz);
    q = '0;
    degen = (t2 == 0) || (s == 0);
    if (degen) return q;
    rhs = (t2 * 128'd12) << 32;
    for (int b = Q_BITS - 1; b >= 0; b--) begin
      cand = q | (Q_BITS'(1) << b);
      if (cand <= Q_ONE) begin
        lhs = 128'(cand) * s;
        lhs = lhs * lhs;
        if (lhs <= rhs) q = cand;
      end
    end
    return q;
  endfunction

  function automatic out_t predict_face(in_t t);
    out_t r;
    logic degen;
    logic [63:0] mean;
    r = '0;
    r.face_quality = shape_quality(t, degen);
    r.degenerate = degen;
    r.is_last = t.last_face;
    if (r.face_quality < worst_quality) worst_quality = r.face_quality;
    if (face_total < COUNT_MAX) begin
      face_total++;
      quality_total += 64'(r.face_quality);
    end
    r.min_quality = worst_quality;
    if (t.last_face) begin
      mean = (face_total != 0) ? quality_total / face_total : 64'd0;
      if (mean > 64'(Q_ONE)) mean = 64'(Q_ONE);
      r.mean_quality = mean[Q_BITS-1:0];
      face_total = 0;
      quality_total = 0;
      worst_quality = Q_ONE;
    end
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      face_total = 0;
      quality_total = 0;
      worst_quality = Q_ONE;
      expected_results.delete();
      fail_count = 0;
      degen_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(), predict_face(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("face_quality", e.face_quality, out_data.face_quality);
          check_field("min_quality", e.min_quality, out_data.min_quality);
          check_field("mean_quality", e.mean_quality, out_data.mean_quality);
          check_field("degenerate", e.degenerate, out_data.degenerate);
          check_field("is_last", e.is_last, out_data.is_last);
          if (e.degenerate) degen_seen++;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- bench/tb_mesh_triangle_quality_stats_core.sv -----
// Testbench top: triangle stimulus, flow control phases and the final verdict.
module tb_mesh_triangle_quality_stats_core;
  import mtqs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // No acceptance on either side for this long means the block hung. The
  // slowest face is a non-degenerate last face; a 64% receiver stall stretches that a bit.
  localparam int HANG_LIMIT = 20000;
  localparam int IN_W = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int fail_count, pending, degen_seen;
  int send_idle_pct = 0;   // chance per cycle of the sender idling
  int recv_stall_pct = 0;  // chance per cycle of out_ready low
  int idle_cycles = 0;
  int faces_sent = 0;
  int meshes_closed = 0;

  always #5 clk = ~clk;

  mesh_triangle_quality_stats_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mtqs_quality_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .degen_seen(degen_seen)
  );

  // Receiver backpressure, redrawn each cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang watchdog.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
        $display("mesh_triangle_quality_stats_core regression: fail");
        $finish;
      end
    end
  end

  // Drive one triangle request and hold it until accepted. in_ready is
  // sampled at the falling edge so the handshake decision is race free.
  task automatic send_face(in_t t);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    faces_sent++;
    if (t.last_face) meshes_closed++;
  endtask

  function automatic in_t make_face(int a0, int a1, int a2, int b0, int b1, int b2,
                                    int c0, int c1, int c2, bit last);
    in_t t;
    t.ax = COORD_BITS'(a0); t.ay = COORD_BITS'(a1); t.az = COORD_BITS'(a2);
    t.bx = COORD_BITS'(b0); t.by_coord = COORD_BITS'(b1); t.bz = COORD_BITS'(b2);
    t.cx = COORD_BITS'(c0); t.cy = COORD_BITS'(c1); t.cz = COORD_BITS'(c2);
    t.last_face = last;
    return t;
  endfunction

  // Mostly small, well-shaped meshes near a random origin; some full-range
  // coordinates so every input bit toggles; some slivers and collapsed faces.
  function automatic in_t random_face();
    in_t t;
    int base, span, kind;
    kind = $urandom_range(99);
    if (kind < 30) begin
      t = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    end else begin
      base = $urandom_range(0, 60000) - 30000;
      span = (kind < 60) ? 16 : 2000;
      t.ax = COORD_BITS'(base + $urandom_range(0, span));
      t.ay = COORD_BITS'(base + $urandom_range(0, span));
      t.az = COORD_BITS'(base + $urandom_range(0, span));
      t.bx = COORD_BITS'(base + $urandom_range(0, span));
      t.by_coord = COORD_BITS'(base + $urandom_range(0, span));
      t.bz = COORD_BITS'(base + $urandom_range(0, span));
      t.cx = COORD_BITS'(base + $urandom_range(0, span));
      t.cy = COORD_BITS'(base + $urandom_range(0, span));
      t.cz = COORD_BITS'(base + $urandom_range(0, span));
      if (kind >= 92) begin
        // collapse: c on a, or c on the line through a and b
        t.cx = COORD_BITS'(t.ax + 2 * (t.bx - t.ax));
        t.cy = COORD_BITS'(t.ay + 2 * (t.by_coord - t.ay));
        t.cz = COORD_BITS'(t.az + 2 * (t.bz - t.az));
        if (kind >= 96) begin
          t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
        end
      end
    end
    t.last_face = ($urandom_range(11) == 0);
    return t;
  endfunction

  initial begin
    in_t seq[$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: equilateral (quality one), corners, degenerate shapes,
    // single-face mesh, mesh closing after degenerate faces.
    seq.insert(seq.size(), make_face(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b1));
    seq.insert(seq.size(), make_face(-32768, -32768, -32768, 32767, -32768, -32768,
                                     -32768, 32767, 32767, 1'b0));
    seq.insert(seq.size(), make_face(32767, 32767, 32767, -32768, 32767, 32767,
                                     32767, -32768, -32768, 1'b0));
    seq.insert(seq.size(), make_face(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, 1'b0));
    seq.insert(seq.size(), make_face(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 1'b1));
    seq.insert(seq.size(), make_face(0, 0, 0, 1, 1, 1, 2, 2, 2, 1'b0));
    seq.insert(seq.size(), make_face(5, 5, 5, 5, 5, 5, 9, 0, -3, 1'b0));
    seq.insert(seq.size(), make_face(0, 0, 0, 32767, 0, 0, 0, 1, 0, 1'b0));
    seq.insert(seq.size(), make_face(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 1'b0));
    seq.insert(seq.size(), make_face(0, 0, 0, 3, 0, 0, 0, 4, 0, 1'b1));
    seq.insert(seq.size(), make_face(-1, -1, -1, 0, 0, 0, 1, 1, 1, 1'b1));
    seq.insert(seq.size(), make_face(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0));
    seq.insert(seq.size(), make_face(-32768, 32767, -32768, 32767, -32768, 32767,
                                     -32768, -32768, 32767, 1'b1));
    foreach (seq[i]) send_face(seq[i]);

    // Random phases: free flow, slow sender, stalled receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 64) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 64) : 0;
      for (int n = 0; n < 225; n++) begin
        send_face(random_face());
        if (ph == 1 && n == 100) begin
          // let the pipeline drain completely mid-phase
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    send_face(make_face(7, -3, 2, 40, 11, -9, -5, 30, 17, 1'b1));
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("covered %0d faces in %0d closed meshes, %0d degenerate results,",
             faces_sent, meshes_closed, degen_seen);
    $display("under free flow, sender gaps, receiver stalls and both combined");
    if (fail_count == 0) begin
      $display("mesh_triangle_quality_stats_core regression: pass");
    end else begin
      $display("mesh_triangle_quality_stats_core regression: fail");
    end
    $finish;
  end

endmodule
